[rtl/core/oot_pkg.sv]
// Shared constants and sine table for the oriented box overlap test.
package oot_pkg;

   localparam int TRIG_WIDTH = 16;   // signed Q1.15 sine and cosine
   localparam int TAB_BITS   = 6;    // quarter-wave table index width

   function automatic logic [14:0] sin_tab(input logic [6:0] idx);
      logic [14:0] v;
      case (idx)
         7'd0: v = 15'd0;      7'd1: v = 15'd804;    7'd2: v = 15'd1608;
         7'd3: v = 15'd2410;   7'd4: v = 15'd3212;   7'd5: v = 15'd4011;
         7'd6: v = 15'd4808;   7'd7: v = 15'd5602;   7'd8: v = 15'd6393;
         7'd9: v = 15'd7179;   7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
         7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
         7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13279;
         7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
         7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
         7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
         7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
         7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
         7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
         7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
         7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
         7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
         7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
         7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
         7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
         7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
         7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
         7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
         7'd63: v = 15'd32757; default: v = 15'd32767;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/obb_obb_overlap_test.sv]
// Top level of the oriented box overlap test.
//
// Oriented box overlap test by separating axes, fully pipelined.
// Input channel req_*: one word per box pair; req_tdata packs both boxes.
// Result channel rsp_*: one word per pair, rsp_tdata[0] is hit (1 = overlap,
// touching counts), upper bits zero.
// Throughput: one word per cycle unless the output stalls; words are independent.
// Stages from acceptance to rsp_tvalid: three of table sine/cosine (table
// read, interpolation multiply, sign), then four of axis projection (trig
// dot products, radius multiply, sums, compare) and the output register.
// The whole pipe advances together and freezes while the output register holds
// an unaccepted word; req_tready is low only in that case, so a stall loses
// and repeats nothing. Bubbles travel as cleared valid bits.
// Reset clears all valid bits; payload registers are not reset.
module obb_obb_overlap_test #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 16,
   parameter int ANGLE_WIDTH   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_center_x, first_center_y, first_half_width, first_half_height,
   // first_angle, second_center_x, second_center_y, second_half_width,
   // second_half_height, second_angle, zero fill
   input  logic [((8*COORD_WIDTH-4+2*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata   // hit, zero fill
);
   localparam int CW = COORD_WIDTH;
   localparam int HW = COORD_WIDTH - 1;
   localparam int AW = ANGLE_WIDTH;
   localparam int TW = oot_pkg::TRIG_WIDTH;
   localparam int BOX = 2*CW + 2*HW + AW;
   localparam int DEPTH = 7;
   // scale is common to every coordinate, so it takes no part in the logic
   localparam int UNUSED_FRAC = FRACTION_BITS;

   logic en;
   logic [DEPTH-1:0] vld_ff;
   logic hit_ff;
   logic out_vld_ff;

   assign en = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // field unpack
   logic signed [CW-1:0] ax, ay, bx, by;
   logic [HW-1:0] aw, ah, bw, bh;
   logic [AW-1:0] aa, ba;
   assign ax = req_tdata[0 +: CW];
   assign ay = req_tdata[CW +: CW];
   assign aw = req_tdata[2*CW +: HW];
   assign ah = req_tdata[2*CW+HW +: HW];
   assign aa = req_tdata[2*CW+2*HW +: AW];
   assign bx = req_tdata[BOX +: CW];
   assign by = req_tdata[BOX+CW +: CW];
   assign bw = req_tdata[BOX+2*CW +: HW];
   assign bh = req_tdata[BOX+2*CW+HW +: HW];
   assign ba = req_tdata[BOX+2*CW+2*HW +: AW];

   logic signed [TW-1:0] ac, as_, bc, bs;
   oot_trig #(.ANGLE_WIDTH(AW)) u_trig_a (
      .clock(clock), .en(en), .angle(aa), .cos_out(ac), .sin_out(as_));
   oot_trig #(.ANGLE_WIDTH(AW)) u_trig_b (
      .clock(clock), .en(en), .angle(ba), .cos_out(bc), .sin_out(bs));

   // geometry delayed alongside the trig pipe (three stages)
   logic signed [CW:0] dx_ff[3], dy_ff[3];
   logic [HW-1:0] g_ff[3][4];
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff[0] <= (CW+1)'(bx) - (CW+1)'(ax);
         dy_ff[0] <= (CW+1)'(by) - (CW+1)'(ay);
         g_ff[0][0] <= aw; g_ff[0][1] <= ah; g_ff[0][2] <= bw; g_ff[0][3] <= bh;
         for (int s = 1; s < 3; s++) begin
            dx_ff[s] <= dx_ff[s-1]; dy_ff[s] <= dy_ff[s-1];
            for (int k = 0; k < 4; k++) g_ff[s][k] <= g_ff[s-1][k];
         end
      end
   end

   logic signed [TW-1:0] ux[4], uy[4];
   logic [3:0] ov;
   assign ux[0] = ac;    assign uy[0] = as_;
   assign ux[1] = -as_;  assign uy[1] = ac;
   assign ux[2] = bc;    assign uy[2] = bs;
   assign ux[3] = -bs;   assign uy[3] = bc;

   for (genvar k = 0; k < 4; k++) begin : g_axis
      oot_axis_test #(.COORD_WIDTH(CW)) u_axis (
         .clock(clock), .en(en), .ux(ux[k]), .uy(uy[k]),
         .dx(dx_ff[2]), .dy(dy_ff[2]),
         .aw(g_ff[2][0]), .ah(g_ff[2][1]), .bw(g_ff[2][2]), .bh(g_ff[2][3]),
         .ac(ac), .as_(as_), .bc(bc), .bs(bs), .overlap(ov[k]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
         out_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) hit_ff <= &ov;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {7'(UNUSED_FRAC & 0), hit_ff};
endmodule

[rtl/core/oot_trig.sv]
// Pipelined table sine and cosine for one binary angle (three register stages).
module oot_trig #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output logic signed [oot_pkg::TRIG_WIDTH-1:0] cos_out,
   output logic signed [oot_pkg::TRIG_WIDTH-1:0] sin_out
);
   localparam int PW = ANGLE_WIDTH - 2;          // phase within a quarter
   localparam int FB = ANGLE_WIDTH - 8;          // interpolation fraction bits
   localparam int FBW = (FB > 0) ? FB : 1;       // fraction register width
   localparam logic [PW:0] QUARTER = (PW+1)'(1) << PW;

   // lane 0 sine, lane 1 cosine
   logic [PW:0]  ph [2];
   logic         neg[2];
   logic [14:0]  base_in[2], base_ff[2];
   logic [15:0]  diff_in[2], diff_ff[2];
   logic [FBW-1:0] frac_in[2], frac_ff[2];
   logic         neg1_ff[2], neg2_ff[2];
   logic [15+FB:0] prod_in[2], prod_ff[2];
   logic [14:0]  base2_ff[2];
   logic [15:0]  mag[2];
   logic signed [15:0] res_in[2], res_ff[2];

   always_comb begin
      logic [ANGLE_WIDTH-1:0] a;
      logic [1:0] q;
      logic [PW-1:0] p;
      logic [PW:0] idx;
      for (int l = 0; l < 2; l++) begin
         a = (l == 1) ? angle + ANGLE_WIDTH'(QUARTER) : angle;
         q = a[ANGLE_WIDTH-1 -: 2];
         p = a[PW-1:0];
         ph[l] = q[0] ? QUARTER - {1'b0, p} : {1'b0, p};
         neg[l] = q[1];
         idx = ph[l] >> FB;
         // no interpolation when the angle has no bits below the table index
         frac_in[l] = (FB > 0) ? ph[l][FBW-1:0] : '0;
         if (idx >= (PW+1)'(64)) begin
            base_in[l] = oot_pkg::sin_tab(7'd64);
            diff_in[l] = 16'd0;
            frac_in[l] = '0;
         end else begin
            base_in[l] = oot_pkg::sin_tab(idx[6:0]);
            diff_in[l] = {1'b0, oot_pkg::sin_tab(idx[6:0] + 7'd1)} - {1'b0, base_in[l]};
         end
         prod_in[l] = (16+FB)'(diff_ff[l]) * (16+FB)'(frac_ff[l]);
         mag[l] = {1'b0, base2_ff[l]} + 16'(prod_ff[l] >> FB);
         res_in[l] = neg2_ff[l] ? -$signed(mag[l]) : $signed(mag[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            base_ff[l] <= base_in[l]; diff_ff[l] <= diff_in[l];
            frac_ff[l] <= frac_in[l]; neg1_ff[l] <= neg[l];
            prod_ff[l] <= prod_in[l]; base2_ff[l] <= base_ff[l];
            neg2_ff[l] <= neg1_ff[l];
            res_ff[l] <= res_in[l];
         end
      end
   end

   assign sin_out = res_ff[0];
   assign cos_out = res_ff[1];
endmodule

[rtl/core/oot_axis_test.sv]
// Pipelined overlap test of both boxes on one axis (four register stages).
module oot_axis_test #(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic en,
   input  logic signed [oot_pkg::TRIG_WIDTH-1:0] ux, uy,
   input  logic signed [COORD_WIDTH:0]           dx, dy,
   input  logic [COORD_WIDTH-2:0]                aw, ah, bw, bh,
   input  logic signed [oot_pkg::TRIG_WIDTH-1:0] ac, as_, bc, bs,
   output logic                                  overlap
);
   localparam int TW = oot_pkg::TRIG_WIDTH;
   localparam int DW = COORD_WIDTH + 1 + TW;      // d products
   localparam int TT = 2*TW + 1;                  // trig dot products
   localparam int RW = COORD_WIDTH - 1 + TT;      // radius products
   localparam int SW = RW + 3;

   // stage 1: trig dot products and centre products
   logic signed [TT-1:0] t_in[4], t_ff[4];
   logic signed [DW-1:0] px_ff, py_ff;
   logic [COORD_WIDTH-2:0] w1_ff[4];
   // stage 2: radius products and centre sum
   logic [RW-1:0] r_ff[4];
   logic signed [DW:0] d_ff;
   // stage 3: sums
   logic [SW-1:0] rs_ff;
   logic [DW+15:0] ds_ff;
   logic ov_ff;

   always_comb begin
      t_in[0] = TT'(ac*ux) + TT'(as_*uy);
      t_in[1] = TT'(ac*uy) - TT'(as_*ux);
      t_in[2] = TT'(bc*ux) + TT'(bs*uy);
      t_in[3] = TT'(bc*uy) - TT'(bs*ux);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) t_ff[k] <= t_in[k];
         px_ff <= DW'(dx) * DW'(ux);
         py_ff <= DW'(dy) * DW'(uy);
         w1_ff[0] <= aw; w1_ff[1] <= ah; w1_ff[2] <= bw; w1_ff[3] <= bh;
         for (int k = 0; k < 4; k++)
            r_ff[k] <= RW'(w1_ff[k]) *
                       RW'(t_ff[k][TT-1] ? TT'(-t_ff[k]) : t_ff[k]);
         d_ff <= (DW+1)'(px_ff) + (DW+1)'(py_ff);
         rs_ff <= SW'(r_ff[0]) + SW'(r_ff[1]) + SW'(r_ff[2]) + SW'(r_ff[3]);
         ds_ff <= (DW+16)'(d_ff[DW] ? (DW+1)'(-d_ff) : d_ff) << 15;
         ov_ff <= (DW+SW+16)'(ds_ff) <= (DW+SW+16)'(rs_ff);
      end
   end

   assign overlap = ov_ff;
endmodule

[sim/testbench.sv]
// Self-checking bench for the oriented box overlap test: directed and random box pairs.
module testbench;

   localparam int WORD_BITS   = 288;   // 284 bits of payload, zero filled to bytes
   localparam int RANDOM_WORDS = 800;
   localparam int HOLD_AFTER  = 300;   // accepted words before the long result stall
   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 20;   // margin after the scoreboard empties

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        hw;
      logic [30:0]        hh;
      logic [15:0]        ang;
   } box_type;

   // Holds the hit flags still owed by the pipe and predicts new ones.
   class overlap_board;
      bit pending_hits[$];
      int errors;
      int words_in;
      int unsigned quarter_tab[65];

      function new();
         quarter_tab = '{0, 804, 1608, 2410, 3212, 4011, 4808, 5602,
            6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
            12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
            18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
            23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
            27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
            30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
            32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757, 32767};
         errors = 0;
         words_in = 0;
      endfunction

      // interpolated quarter wave, phase 0..16384
      function longint quarter_wave(int unsigned ph);
         int unsigned idx, frac;
         idx = ph >> 8;
         frac = ph & 255;
         if (idx >= 64) return quarter_tab[64];
         return quarter_tab[idx] + (((quarter_tab[idx+1] - quarter_tab[idx]) * frac) >> 8);
      endfunction

      function longint sine_q15(int unsigned a);
         int unsigned quad, ph;
         longint v;
         a = a & 16'hFFFF;
         quad = a >> 14;
         ph = a & 16'h3FFF;
         v = quad[0] ? quarter_wave(16384 - ph) : quarter_wave(ph);
         return quad[1] ? -v : v;
      endfunction

      function logic signed [127:0] magnitude(longint v);
         logic signed [127:0] m;
         m = v;
         return (m < 0) ? -m : m;
      endfunction

      // projection half length of one box on axis (ux, uy)
      function logic signed [127:0] reach(longint w, longint h, longint c, longint s,
                                          longint ux, longint uy);
         logic signed [127:0] wl, hl;
         wl = w;
         hl = h;
         return wl * magnitude(c * ux + s * uy) + hl * magnitude(c * uy - s * ux);
      endfunction

      function bit boxes_overlap(word_type w);
         longint ax, ay, aw, ah, ac, as_, bx, by, bw, bh, bc, bs, dx, dy;
         longint ux[4], uy[4];
         logic signed [127:0] gap, span;
         bit hit;
         ax = longint'($signed(w[31:0]));
         ay = longint'($signed(w[63:32]));
         aw = longint'(w[94:64]);
         ah = longint'(w[125:95]);
         ac = sine_q15(w[141:126] + 16384);
         as_ = sine_q15(w[141:126]);
         bx = longint'($signed(w[173:142]));
         by = longint'($signed(w[205:174]));
         bw = longint'(w[236:206]);
         bh = longint'(w[267:237]);
         bc = sine_q15(w[283:268] + 16384);
         bs = sine_q15(w[283:268]);
         dx = bx - ax;
         dy = by - ay;
         ux = '{ac, -as_, bc, -bs};
         uy = '{as_, ac, bs, bc};
         hit = 1;
         for (int k = 0; k < 4; k++) begin
            gap = magnitude(dx * ux[k] + dy * uy[k]) * 32768;
            span = reach(aw, ah, ac, as_, ux[k], uy[k]) + reach(bw, bh, bc, bs, ux[k], uy[k]);
            if (gap > span) hit = 0;
         end
         return hit;
      endfunction

      function void note_pair(word_type w);
         pending_hits.push_back(boxes_overlap(w));
         words_in++;
      endfunction

      function void check_hit(logic [7:0] d);
         bit want;
         if (pending_hits.size() == 0) begin
            $error("hit: result word with nothing outstanding, actual %0d", d[0]);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (d[0] !== want) begin
            $error("hit: expected %0d, actual %0d", want, d[0]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   word_type req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [7:0] rsp_tdata;

   overlap_board board;
   bit quiet = 0;        // no idling on either side while set
   int stall_count = 0;

   obb_obb_overlap_test i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic word_type pack_pair(box_type a, box_type b);
      word_type w;
      w = '0;
      w[31:0] = a.cx;    w[63:32] = a.cy;   w[94:64] = a.hw;
      w[125:95] = a.hh;  w[141:126] = a.ang;
      w[173:142] = b.cx; w[205:174] = b.cy; w[236:206] = b.hw;
      w[267:237] = b.hh; w[283:268] = b.ang;
      return w;
   endfunction

   function automatic box_type make_box(logic signed [31:0] cx, logic signed [31:0] cy,
                                        logic [30:0] hw, logic [30:0] hh, logic [15:0] ang);
      box_type b;
      b.cx = cx; b.cy = cy; b.hw = hw; b.hh = hh; b.ang = ang;
      return b;
   endfunction

   // mostly boxes in a small neighbourhood so hits and misses both occur;
   // the rest spans every bit of every field
   function automatic box_type random_box(bit near);
      box_type b;
      if (near) begin
         b.cx = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         b.cy = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         b.hw = 31'($urandom_range(0, 32'h0018_0000));
         b.hh = 31'($urandom_range(0, 32'h0018_0000));
      end else begin
         b.cx = $urandom;
         b.cy = $urandom;
         b.hw = 31'($urandom);
         b.hh = 31'($urandom);
      end
      b.ang = 16'($urandom);
      return b;
   endfunction

   // one word offered until taken; valid stays high across back-to-back words
   task automatic send_pair(word_type w);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   // accepted words, sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_pair(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_hit(rsp_tdata);
   end

   // receiver: random back-pressure plus one long hold to fill the pipe
   initial begin
      bit held;
      held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && board.words_in >= HOLD_AFTER) begin
            held = 1;
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 10);
      end
   end

   // watchdog on handshakes
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] c_min, c_max, one;
      logic [30:0] e_max, e_one;
      board = new();
      c_min = 32'sh8000_0000;
      c_max = 32'sh7FFF_FFFF;
      e_max = 31'h7FFF_FFFF;
      one = 32'sh0001_0000;
      e_one = 31'h0001_0000;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: extremes, cardinal angles, touching and just-apart, degenerate boxes
      send_pair(pack_pair(make_box(0, 0, e_one, e_one, 0),
                          make_box(2 * one, 0, e_one, e_one, 0)));
      send_pair(pack_pair(make_box(0, 0, e_one, e_one, 0),
                          make_box(2 * one + 1, 0, e_one, e_one, 0)));
      send_pair(pack_pair(make_box(0, 0, e_one, e_one, 16'h4000),
                          make_box(0, 2 * one, e_one, e_one, 16'h4000)));
      send_pair(pack_pair(make_box(0, 0, e_one, e_one, 16'h2000),
                          make_box(3 * one, 0, e_one, e_one, 16'h6000)));
      send_pair(pack_pair(make_box(0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 16'hFFFF)));
      send_pair(pack_pair(make_box(0, 0, 0, 0, 0), make_box(1, 0, 0, 0, 0)));
      send_pair(pack_pair(make_box(0, 0, 0, e_one, 16'h8000),
                          make_box(0, 0, e_one, 0, 16'hC000)));
      send_pair(pack_pair(make_box(c_min, c_min, 0, 0, 0),
                          make_box(c_max, c_max, 0, 0, 16'h8000)));
      send_pair(pack_pair(make_box(c_min, c_max, e_max, e_max, 16'h4000),
                          make_box(c_max, c_min, e_max, e_max, 16'hC000)));
      send_pair(pack_pair(make_box(c_min, 0, e_max, 0, 16'hFFFF),
                          make_box(c_max, 0, e_max, 0, 16'h0001)));
      send_pair(pack_pair(make_box(c_max, c_max, e_max, e_max, 16'hFFFF),
                          make_box(c_max, c_max, e_max, e_max, 16'hFFFF)));
      send_pair(pack_pair(make_box(c_min, c_min, 1, 1, 16'h3FFF),
                          make_box(c_max, c_max, 1, 1, 16'h4001)));
      send_pair(pack_pair(make_box(-one, -one, e_one, e_one, 16'h7FFF),
                          make_box(one, one, 0, 0, 16'h8001)));
      send_pair(pack_pair(make_box(0, 0, e_max, 1, 16'h1234),
                          make_box(0, c_max, 1, e_max, 16'hBEEF)));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 500 && n < 650);
         send_pair(pack_pair(random_box($urandom_range(0, 99) < 70),
                             random_box($urandom_range(0, 99) < 70)));
      end
      quiet = 0;
      req_tvalid <= 0;

      // let the last accepted word reach the scoreboard first
      @(posedge clock);
      while (board.pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
